// ----- design/fpalu_pkg.sv -----
// package for the fixed-point alu: data widths, operation codes and the pipeline word
// no dependencies
`default_nettype none
package fpalu_pkg;

  localparam int IN_W       = 32;
  localparam int OUT_W      = 32;
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 8;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int NUM_W      = DATA_WIDTH + FRAC_BITS;
  localparam int DIV_STAGES = (NUM_W + 1) / 2;
  localparam int NQ_W       = 2 * DIV_STAGES;

  typedef enum logic [3:0] {
    KIND_ADD      = 4'd0,
    KIND_SUB      = 4'd1,
    KIND_MUL      = 4'd2,
    KIND_DIV      = 4'd3,
    KIND_GT       = 4'd4,
    KIND_LT       = 4'd5,
    KIND_GE       = 4'd6,
    KIND_LE       = 4'd7,
    KIND_EQ       = 4'd8,
    KIND_NE       = 4'd9,
    KIND_MIN      = 4'd10,
    KIND_MAX      = 4'd11,
    KIND_INC      = 4'd12,
    KIND_DEC      = 4'd13,
    KIND_TO_INT   = 4'd14,
    KIND_FROM_INT = 4'd15
  } kind_t;

  typedef struct packed {
    kind_t                         kind;
    logic signed [DATA_WIDTH-1:0]  simple;
    logic signed [PROD_W-1:0]      prod;
    logic [NQ_W-1:0]               quo;
    logic [DATA_WIDTH-1:0]         rem;
    logic [DATA_WIDTH-1:0]         den;
    logic                          neg;
    logic                          dz;
    logic                          cmp;
  } pipe_t;

endpackage
`default_nettype wire

// ----- design/fpalu_if.sv -----
// handshake channels of the fixed-point alu: operation beats in, result beats out
// depends on fpalu_pkg
`default_nettype none
interface fpalu_in_if;
  logic                              valid;
  logic                              ready;
  logic [3:0]                        kind;
  logic signed [fpalu_pkg::IN_W-1:0] operand_x;
  logic signed [fpalu_pkg::IN_W-1:0] operand_y;
  modport source (output valid, kind, operand_x, operand_y, input ready);
  modport sink (input valid, kind, operand_x, operand_y, output ready);
endinterface

interface fpalu_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [fpalu_pkg::OUT_W-1:0] result_value;
  logic                               compare_true;
  logic                               divide_by_zero;
  modport source (output valid, result_value, compare_true, divide_by_zero, input ready);
  modport sink (input valid, result_value, compare_true, divide_by_zero, output ready);
endinterface
`default_nettype wire

// ----- design/fixed_point_alu_unit.sv -----
// top level of the signed fixed-point alu (q24.8 by default)
// depends on fpalu_pkg and the channels in fpalu_if
//
// usage:
//   req carries one operation beat: kind, operand_x, operand_y (raw fixed point)
//   rsp returns one beat per operation: result_value, compare_true, divide_by_zero
//   results come back in the order the operations were taken
// path: an accepted beat is registered in st[0], passes stage registers st[1]
//   to st[NS], then the output register; all take this path so order is kept
// throughput: one beat per cycle when not stalled; divider: two quotient bits
//   per stage over DIV_STAGES stages; the 32x32 multiplier is in the first stage
// stall: when rsp.valid is high and rsp.ready low the whole pipeline holds and
//   req.ready drops; nothing is lost or repeated
// reset: rst clears all valid bits; no result beat is pending afterwards
// divide by a zero divisor gives result zero with divide_by_zero set
`default_nettype none
module fixed_point_alu_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  fpalu_in_if.sink   req,
  fpalu_out_if.source rsp
);

  localparam int DW = fpalu_pkg::DATA_WIDTH;
  localparam int NS = fpalu_pkg::DIV_STAGES;

  fpalu_pkg::pipe_t st [NS+1];
  fpalu_pkg::pipe_t in_next;
  fpalu_pkg::pipe_t st_next [1:NS];
  logic             vld [NS+1];
  logic             advance;

  logic                         out_valid;
  logic signed [fpalu_pkg::OUT_W-1:0] out_value;
  logic                         out_cmp;
  logic                         out_dz;
  logic signed [DW-1:0]         fin_value;

  assign advance   = !out_valid || rsp.ready;
  assign req.ready = advance;
  assign rsp.valid = out_valid;
  assign rsp.result_value   = out_value;
  assign rsp.compare_true   = out_cmp;
  assign rsp.divide_by_zero = out_dz;

  // input stage: operand decode, multiplier, simple ops
  always_comb begin
    logic signed [DW-1:0] xs;
    logic signed [DW-1:0] ys;
    logic [DW-1:0]        xmag;
    logic [DW-1:0]        ymag;
    fpalu_pkg::kind_t     k;
    xs   = signed'(req.operand_x[DW-1:0]);
    ys   = signed'(req.operand_y[DW-1:0]);
    xmag = xs[DW-1] ? DW'(-xs) : DW'(xs);
    ymag = ys[DW-1] ? DW'(-ys) : DW'(ys);
    k    = fpalu_pkg::kind_t'(req.kind);
    in_next.kind   = k;
    in_next.prod   = xs * ys;
    in_next.quo    = fpalu_pkg::NQ_W'(xmag) << fpalu_pkg::FRAC_BITS;
    in_next.rem    = '0;
    in_next.den    = ymag;
    in_next.neg    = xs[DW-1] ^ ys[DW-1];
    in_next.dz     = (k == fpalu_pkg::KIND_DIV) && (ys == '0);
    in_next.simple = '0;
    in_next.cmp    = 1'b0;
    unique case (k)
      fpalu_pkg::KIND_ADD:      in_next.simple = xs + ys;
      fpalu_pkg::KIND_SUB:      in_next.simple = xs - ys;
      fpalu_pkg::KIND_GT:       in_next.cmp = xs > ys;
      fpalu_pkg::KIND_LT:       in_next.cmp = xs < ys;
      fpalu_pkg::KIND_GE:       in_next.cmp = xs >= ys;
      fpalu_pkg::KIND_LE:       in_next.cmp = xs <= ys;
      fpalu_pkg::KIND_EQ:       in_next.cmp = xs == ys;
      fpalu_pkg::KIND_NE:       in_next.cmp = xs != ys;
      fpalu_pkg::KIND_MIN:      in_next.simple = (xs < ys) ? xs : ys;
      fpalu_pkg::KIND_MAX:      in_next.simple = (xs > ys) ? xs : ys;
      fpalu_pkg::KIND_INC:      in_next.simple = xs + DW'(1);
      fpalu_pkg::KIND_DEC:      in_next.simple = xs - DW'(1);
      fpalu_pkg::KIND_TO_INT:   in_next.simple = xs >>> fpalu_pkg::FRAC_BITS;
      fpalu_pkg::KIND_FROM_INT: in_next.simple = xs << fpalu_pkg::FRAC_BITS;
      default:                  in_next.simple = '0;
    endcase
  end

  // divider stages: two restoring steps each
  always_comb begin
    logic [DW:0] trial;
    logic        qbit;
    for (int s = 1; s <= NS; s++) begin
      st_next[s] = st[s-1];
      for (int b = 0; b < 2; b++) begin
        trial = {st_next[s].rem, st_next[s].quo[fpalu_pkg::NQ_W-1]};
        qbit  = trial >= {1'b0, st_next[s].den};
        if (qbit) begin
          trial = trial - {1'b0, st_next[s].den};
        end
        st_next[s].rem = trial[DW-1:0];
        st_next[s].quo = {st_next[s].quo[fpalu_pkg::NQ_W-2:0], qbit};
      end
    end
  end

  // output select
  always_comb begin
    logic signed [fpalu_pkg::PROD_W-1:0] sh;
    logic [DW-1:0]                       qv;
    sh = st[NS].prod >>> fpalu_pkg::FRAC_BITS;
    qv = st[NS].quo[DW-1:0];
    priority case (st[NS].kind)
      fpalu_pkg::KIND_MUL: fin_value = sh[DW-1:0];
      fpalu_pkg::KIND_DIV: begin
        if (st[NS].dz) begin
          fin_value = '0;
        end else begin
          fin_value = st[NS].neg ? signed'(DW'(-qv)) : signed'(qv);
        end
      end
      default:             fin_value = st[NS].simple;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= NS; s++) begin
        vld[s] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (advance) begin
      vld[0] <= req.valid;
      for (int s = 1; s <= NS; s++) begin
        vld[s] <= vld[s-1];
      end
      out_valid <= vld[NS];
    end
    if (advance) begin
      st[0] <= in_next;
      for (int s = 1; s <= NS; s++) begin
        st[s] <= st_next[s];
      end
      out_value <= fpalu_pkg::OUT_W'(fin_value);
      out_cmp   <= st[NS].cmp;
      out_dz    <= st[NS].dz;
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/tb_fixed_point_alu_unit.sv -----
// testbench for fixed_point_alu_unit: directed table then random operation beats,
// each result beat checked against a table value or a built-in q-format predictor
// depends on fpalu_pkg, fpalu_in_if and fpalu_out_if
`default_nettype none
module tb_fixed_point_alu_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] value;
    logic               cmp;
    logic               dz;
  } alu_res_t;

  typedef struct {
    fpalu_pkg::kind_t   kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               known;
    alu_res_t           res;
  } op_row_t;

  localparam logic signed [31:0] MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  fpalu_in_if  req ();
  fpalu_out_if rsp ();

  fixed_point_alu_unit uut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always #4 clk = ~clk;

  alu_res_t pending_results[$];
  int       errors = 0;
  bit       send_done = 0;
  bit       long_hold = 0;
  op_row_t  rows[$];

  function automatic alu_res_t fx_compute(fpalu_pkg::kind_t k, logic signed [31:0] a,
                                          logic signed [31:0] b);
    alu_res_t          r;
    logic signed [63:0] wa, wb, full;
    wa = a;
    wb = b;
    full = 0;
    r.cmp = 1'b0;
    r.dz = 1'b0;
    case (k)
      fpalu_pkg::KIND_ADD:      full = wa + wb;
      fpalu_pkg::KIND_SUB:      full = wa - wb;
      fpalu_pkg::KIND_MUL:      full = (wa * wb) >>> fpalu_pkg::FRAC_BITS;
      fpalu_pkg::KIND_DIV: begin
        if (b == 0) r.dz = 1'b1;
        else full = (wa * (64'sd1 <<< fpalu_pkg::FRAC_BITS)) / wb;
      end
      fpalu_pkg::KIND_GT:       r.cmp = a > b;
      fpalu_pkg::KIND_LT:       r.cmp = a < b;
      fpalu_pkg::KIND_GE:       r.cmp = a >= b;
      fpalu_pkg::KIND_LE:       r.cmp = a <= b;
      fpalu_pkg::KIND_EQ:       r.cmp = a == b;
      fpalu_pkg::KIND_NE:       r.cmp = a != b;
      fpalu_pkg::KIND_MIN:      full = (a < b) ? wa : wb;
      fpalu_pkg::KIND_MAX:      full = (a > b) ? wa : wb;
      fpalu_pkg::KIND_INC:      full = wa + 1;
      fpalu_pkg::KIND_DEC:      full = wa - 1;
      fpalu_pkg::KIND_TO_INT:   full = wa >>> fpalu_pkg::FRAC_BITS;
      default:                  full = wa * (64'sd1 <<< fpalu_pkg::FRAC_BITS);
    endcase
    r.value = full[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return MAXV - $urandom_range(0, 3);
      1: return MINV + $urandom_range(0, 3);
      2: return $urandom_range(0, 7) - 4;
      3: return $signed($urandom_range(0, 65535)) - 32768;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(fpalu_pkg::kind_t k, logic signed [31:0] a,
                         logic signed [31:0] b,
                         logic known = 0, logic signed [31:0] v = 0,
                         logic c = 0, logic d = 0);
    op_row_t row;
    row.kind = k;
    row.x = a;
    row.y = b;
    row.known = known;
    row.res.value = v;
    row.res.cmp = c;
    row.res.dz = d;
    rows.push_back(row);
  endtask

  task automatic send_beat(fpalu_pkg::kind_t k, logic signed [31:0] a,
                           logic signed [31:0] b);
    int gap;
    gap = long_hold ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.kind <= k;
    req.operand_x <= a;
    req.operand_y <= b;
    do @(posedge clk); while (!req.ready);
  endtask

  initial begin
    fpalu_pkg::kind_t k;
    logic signed [31:0] a, b;
    req.valid = 1'b0;
    req.kind = fpalu_pkg::KIND_ADD;
    req.operand_x = 0;
    req.operand_y = 0;
    rsp.ready = 1'b0;
    add_row(fpalu_pkg::KIND_ADD, MAXV, 32'sd1, 1, MINV);
    add_row(fpalu_pkg::KIND_SUB, MINV, 32'sd1, 1, MAXV);
    add_row(fpalu_pkg::KIND_MUL, MAXV, MAXV);
    add_row(fpalu_pkg::KIND_MUL, MINV, MINV);
    add_row(fpalu_pkg::KIND_MUL, -32'sd1, 32'sd1, 1, -32'sd1);
    add_row(fpalu_pkg::KIND_DIV, 32'sd256, 32'sd0, 1, 32'sd0, 0, 1);
    add_row(fpalu_pkg::KIND_DIV, MINV, -32'sd1);
    add_row(fpalu_pkg::KIND_DIV, -32'sd3, 32'sd2);
    add_row(fpalu_pkg::KIND_GT, MAXV, MINV, 1, 0, 1);
    add_row(fpalu_pkg::KIND_LT, MAXV, MINV, 1, 0, 0);
    add_row(fpalu_pkg::KIND_GE, 32'sd5, 32'sd5, 1, 0, 1);
    add_row(fpalu_pkg::KIND_LE, MINV, MINV, 1, 0, 1);
    add_row(fpalu_pkg::KIND_EQ, 32'sd7, 32'sd7, 1, 0, 1);
    add_row(fpalu_pkg::KIND_NE, 32'sd7, 32'sd7, 1, 0, 0);
    add_row(fpalu_pkg::KIND_MIN, 32'sd9, 32'sd9);
    add_row(fpalu_pkg::KIND_MAX, MINV, MAXV, 1, MAXV);
    add_row(fpalu_pkg::KIND_MIN, MINV, MAXV, 1, MINV);
    add_row(fpalu_pkg::KIND_INC, MAXV, 32'sd0, 1, MINV);
    add_row(fpalu_pkg::KIND_DEC, MINV, -32'sd1, 1, MAXV);
    add_row(fpalu_pkg::KIND_TO_INT, -32'sd1, 32'sd0, 1, -32'sd1);
    add_row(fpalu_pkg::KIND_TO_INT, MAXV, 32'sd0, 1, 32'sh007fffff);
    add_row(fpalu_pkg::KIND_FROM_INT, MAXV, 32'sd0, 1, 32'shffffff00);
    add_row(fpalu_pkg::KIND_FROM_INT, MINV, MAXV, 1, 32'sd0);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[i]) begin
      pending_results.push_back(rows[i].known ? rows[i].res :
                                fx_compute(rows[i].kind, rows[i].x, rows[i].y));
      send_beat(rows[i].kind, rows[i].x, rows[i].y);
    end
    for (int n = 0; n < 1600; n++) begin
      if (n == 300) long_hold = 1;
      if (n == 360) long_hold = 0;
      k = fpalu_pkg::kind_t'($urandom_range(0, 15));
      a = rand_operand();
      b = ($urandom_range(0, 9) == 0) ? 32'sd0 :
          ($urandom_range(0, 7) == 0) ? a : rand_operand();
      pending_results.push_back(fx_compute(k, a, b));
      send_beat(k, a, b);
    end
    req.valid <= 1'b0;
    send_done = 1;
  end

  initial begin
    int hold;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        rsp.ready <= 1'b0;
        for (hold = 0; hold < 200; hold++) @(posedge clk);
        long_hold = 0;
      end
      hold = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
      if (hold > 0) begin
        rsp.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    alu_res_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (rsp.result_value !== want.value) begin
          $error("result_value expected %0d actual %0d", want.value, rsp.result_value);
          errors++;
        end
        if (rsp.compare_true !== want.cmp) begin
          $error("compare_true expected %0b actual %0b", want.cmp, rsp.compare_true);
          errors++;
        end
        if (rsp.divide_by_zero !== want.dz) begin
          $error("divide_by_zero expected %0b actual %0b", want.dz, rsp.divide_by_zero);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (send_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
design/fpalu_pkg.sv
design/fpalu_if.sv
design/fixed_point_alu_unit.sv
tb/sv/tb_fixed_point_alu_unit.sv
